### rtl/core/lbcs_pkg.sv
// ----------------------------------------------------------------------------
// LED blink code sequencer package
// Shared types and constants: item structs, phase codes, operation codes,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package lbcs_pkg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] flash_count;
        logic [7:0] on_time;
        logic [7:0] dark_time;
    } cmd_t;

    typedef struct packed {
        logic error_led;
        logic interface_led;
    } led_t;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_ON    = 2'd1,
        PH_OFF   = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SET_ERROR = 2'd1;
    localparam logic [1:0] OP_SET_IFACE = 2'd2;

    typedef enum logic [1:0] {
        CFG_PRESCALE_LIMIT = 2'd0,
        CFG_FLASH_ON       = 2'd1,
        CFG_FLASH_OFF      = 2'd2,
        CFG_PAUSE          = 2'd3
    } cfg_index_t;

    localparam logic [7:0] PRESCALE_LIMIT_RST = 8'hA4;
    localparam logic [7:0] FLASH_ON_RST       = 8'd18;
    localparam logic [7:0] FLASH_OFF_RST      = 8'd18;
    localparam logic [7:0] PAUSE_RST          = 8'd80;

    typedef struct packed {
        logic [7:0] prescale_limit;
        logic [7:0] flash_on_periods;
        logic [7:0] flash_off_periods;
        logic [7:0] pause_periods;
    } cfg_t;

    // Per-item control toward the two sequencers; at most one bit is set.
    typedef struct packed {
        logic period;
        logic set_error;
        logic set_iface;
    } ctrl_t;

endpackage

### rtl/core/lbcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// LED blink code sequencer configuration registers
// Holds the prescaler limit and the error LED phase lengths.
// ----------------------------------------------------------------------------
module lbcs_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  lbcs_pkg::cfg_index_t   cfg_index,
    input  logic [7:0]             cfg_data,
    output lbcs_pkg::cfg_t         cfg
);
    import lbcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PRESCALE_LIMIT: cfg_next.prescale_limit    = cfg_data;
                CFG_FLASH_ON:       cfg_next.flash_on_periods  = cfg_data;
                CFG_FLASH_OFF:      cfg_next.flash_off_periods = cfg_data;
                CFG_PAUSE:          cfg_next.pause_periods     = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale_limit    <= PRESCALE_LIMIT_RST;
            cfg_reg.flash_on_periods  <= FLASH_ON_RST;
            cfg_reg.flash_off_periods <= FLASH_OFF_RST;
            cfg_reg.pause_periods     <= PAUSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/lbcs_error_seq.sv
// ----------------------------------------------------------------------------
// LED blink code sequencer error pattern
// Steps the error LED through flash, gap and pause phases once per slow
// period and takes new error codes.
// ----------------------------------------------------------------------------
module lbcs_error_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  lbcs_pkg::ctrl_t  ctrl,
    input  logic [7:0]       flash_count,
    input  lbcs_pkg::cfg_t   cfg,
    output logic             led_next
);
    import lbcs_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] done_reg, done_next;
    logic [7:0] target_reg, target_next;
    logic       led_reg, led_lvl_next;

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        done_next    = done_reg;
        target_next  = target_reg;
        led_lvl_next = led_reg;
        if (ctrl.period)
        begin
            if (left_reg != 8'd0)
            begin
                left_next = left_reg - 8'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ON:
                    begin
                        if (done_reg != 8'hFF)
                        begin
                            done_next = done_reg + 8'd1;
                        end
                        phase_next   = PH_OFF;
                        left_next    = cfg.flash_off_periods;
                        led_lvl_next = 1'b0;
                    end
                    PH_OFF:
                    begin
                        if (done_reg >= target_reg)
                        begin
                            phase_next = PH_PAUSE;
                            left_next  = cfg.pause_periods;
                        end
                        else
                        begin
                            phase_next   = PH_ON;
                            left_next    = cfg.flash_on_periods;
                            led_lvl_next = 1'b1;
                        end
                    end
                    PH_PAUSE:
                    begin
                        done_next    = 8'd0;
                        phase_next   = PH_ON;
                        left_next    = cfg.flash_on_periods;
                        led_lvl_next = 1'b1;
                    end
                    PH_NONE:
                    begin
                        phase_next = PH_NONE;
                    end
                endcase
            end
        end
        else if (ctrl.set_error)
        begin
            // A repeated nonzero code leaves the running pattern alone.
            if (flash_count == 8'd0)
            begin
                phase_next   = PH_NONE;
                led_lvl_next = 1'b0;
            end
            else if (target_reg != flash_count)
            begin
                phase_next = PH_OFF;
            end
            target_next = flash_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NONE;
            left_reg   <= 8'd0;
            done_reg   <= 8'd0;
            target_reg <= 8'd0;
            led_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            done_reg   <= done_next;
            target_reg <= target_next;
            led_reg    <= led_lvl_next;
        end
    end

    assign led_next = led_lvl_next;

`ifndef SYNTHESIS
    a_zero_target_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (target_reg == 8'd0) |-> (phase_reg == PH_NONE))
        else $error("error code zero but pattern not idle");

    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NONE) |-> !led_reg)
        else $error("error LED lit while pattern idle");

    a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.period && left_reg != 8'd0) |=> (left_reg == 8'($past(left_reg) - 8'd1)))
        else $error("period countdown skipped");
`endif

endmodule

### rtl/core/lbcs_iface_seq.sv
// ----------------------------------------------------------------------------
// LED blink code sequencer interface pattern
// Alternates the interface LED between programmable on and off phases,
// or holds it steady lit or dark.
// ----------------------------------------------------------------------------
module lbcs_iface_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  lbcs_pkg::ctrl_t  ctrl,
    input  logic [7:0]       on_time,
    input  logic [7:0]       dark_time,
    output logic             led_next
);
    import lbcs_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] on_len_reg, on_len_next;
    logic [7:0] off_len_reg, off_len_next;
    logic       led_reg, led_lvl_next;

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        on_len_next  = on_len_reg;
        off_len_next = off_len_reg;
        led_lvl_next = led_reg;
        if (ctrl.period)
        begin
            if (left_reg != 8'd0)
            begin
                left_next = left_reg - 8'd1;
            end
            else
            begin
                // The phase names the next level change, so the on phase
                // lights the LED and loads the on length.
                unique case (phase_reg)
                    PH_ON:
                    begin
                        phase_next   = PH_OFF;
                        left_next    = on_len_reg;
                        led_lvl_next = 1'b1;
                    end
                    PH_OFF:
                    begin
                        phase_next   = PH_ON;
                        left_next    = off_len_reg;
                        led_lvl_next = 1'b0;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        else if (ctrl.set_iface)
        begin
            priority if (dark_time == 8'd0)
            begin
                phase_next   = PH_NONE;
                led_lvl_next = 1'b1;
            end
            else if (on_time == 8'd0)
            begin
                phase_next   = PH_NONE;
                led_lvl_next = 1'b0;
            end
            else
            begin
                on_len_next  = on_time;
                off_len_next = dark_time;
                phase_next   = PH_ON;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NONE;
            left_reg    <= 8'd0;
            on_len_reg  <= 8'd0;
            off_len_reg <= 8'd0;
            led_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            on_len_reg  <= on_len_next;
            off_len_reg <= off_len_next;
            led_reg     <= led_lvl_next;
        end
    end

    assign led_next = led_lvl_next;

endmodule

### rtl/core/led_blink_code_sequencer.sv
// ----------------------------------------------------------------------------
// LED blink code sequencer
// Drives an error LED blink code and an interface LED blink from a stream
// of tick and set commands.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel (cmd_valid, cmd_stall, cmd) carries ticks, error code
// writes and interface blink writes. Every command yields one transaction
// on the led channel (led_valid, led_stall, led) with both LED levels as
// they stand after that command.
// A command passes through an input register and, when it moves on, the
// sequencer state is updated and the levels land in the output register,
// so led_valid rises as the command enters the output register. One
// command is taken per cycle when the output side keeps up.
// When led_stall holds the output register, the input register still
// takes one more command; cmd_stall rises only once both registers are
// full, and the block loses no transaction.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// prescale limit and the error LED phase lengths; cfg_ready is always high.
// Reset restores the default register values, clears the prescaler and
// puts both LED sequencers dark and idle; the led output register has no reset.
// ----------------------------------------------------------------------------
module led_blink_code_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  lbcs_pkg::cmd_t        cmd,
    output logic                  led_valid,
    input  logic                  led_stall,
    output lbcs_pkg::led_t        led,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lbcs_pkg::cfg_index_t  cfg_index,
    input  logic [7:0]            cfg_data
);
    import lbcs_pkg::*;

    cfg_t       cfg;
    ctrl_t      ctrl;
    logic       s1_valid_reg, s1_valid_next;
    cmd_t       s1_data_reg;
    logic       led_valid_reg, led_valid_next;
    led_t       led_data_reg;
    logic [7:0] prescale_reg, prescale_next;
    logic       advance;
    logic       accept;
    logic       err_led_next;
    logic       iface_led_next;

    assign cfg_ready = 1'b1;

    lbcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The buffered command moves on whenever the output register is free.
    assign advance   = s1_valid_reg && (!led_valid_reg || !led_stall);
    assign cmd_stall = s1_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        prescale_next = prescale_reg;
        ctrl          = '0;
        if (advance)
        begin
            unique case (s1_data_reg.operation)
                OP_TICK:
                begin
                    if (prescale_reg <= cfg.prescale_limit)
                    begin
                        prescale_next = prescale_reg + 8'd1;
                    end
                    else
                    begin
                        prescale_next = 8'd0;
                        ctrl.period   = 1'b1;
                    end
                end
                OP_SET_ERROR: ctrl.set_error = 1'b1;
                OP_SET_IFACE: ctrl.set_iface = 1'b1;
                default:      ctrl = '0;
            endcase
        end
    end

    lbcs_error_seq u_error (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .flash_count (s1_data_reg.flash_count),
        .cfg         (cfg),
        .led_next    (err_led_next)
    );

    lbcs_iface_seq u_iface (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .on_time   (s1_data_reg.on_time),
        .dark_time (s1_data_reg.dark_time),
        .led_next  (iface_led_next)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        led_valid_next = led_valid_reg;
        if (advance)
        begin
            led_valid_next = 1'b1;
        end
        else if (!led_stall)
        begin
            led_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            led_valid_reg <= 1'b0;
            prescale_reg  <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            led_valid_reg <= led_valid_next;
            prescale_reg  <= prescale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= cmd;
        end
        if (advance)
        begin
            led_data_reg.error_led     <= err_led_next;
            led_data_reg.interface_led <= iface_led_next;
        end
    end

    assign led_valid = led_valid_reg;
    assign led       = led_data_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (s1_valid_reg && led_valid_reg && led_stall))
        else $error("command stalled with room in the pipeline");

    a_free_output_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !led_valid_reg) |=> led_valid_reg)
        else $error("buffered command did not reach the output register");

    a_update_once: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> (ctrl == '0 && prescale_next == prescale_reg))
        else $error("sequencer state changed without a command");
`endif

endmodule
